@@ rtl/mpq_pkg.sv @@
package mpq_pkg;

    localparam int DEPTH   = 16;
    localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int DATA_W  = 32;
    localparam int COUNT_OUT_W = 5;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_REMOVE = 1'b1;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_EMPTY = 2'd1;
    localparam logic [1:0] STATUS_FULL  = 2'd2;

endpackage

@@ rtl/mpq_ram.sv @@
module mpq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                             clk,
    input  logic                             we,
    input  logic [$clog2(DEPTH)-1:0]         wr_addr,
    input  logic [WIDTH-1:0]                 wr_data,
    input  logic [$clog2(DEPTH)-1:0]         rd_addr,
    output logic [WIDTH-1:0]                 rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

@@ rtl/min_priority_queue.sv @@
// Bounded min-priority queue of signed 32-bit values, kept unsorted in arrival
// order. Raise start with opcode and value while busy is low; the item is taken
// on that edge. Each item returns exactly one result, flagged by done for a
// single cycle, and the receiver cannot stall it. Inserts and removes on an
// empty queue answer in the next cycle and leave busy low. A remove on a non-empty
// queue of N entries scans the store for the oldest smallest value through one
// comparator, one entry per cycle, then moves the later entries down one slot
// per cycle through the single RAM read port. entry_count and is_empty are valid
// with done.
module min_priority_queue
    import mpq_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic                     opcode,
    input  logic signed [31:0]       value,
    output logic                     done,
    output logic [1:0]               status,
    output logic signed [31:0]       removed_value,
    output logic [COUNT_OUT_W-1:0]   entry_count,
    output logic                     is_empty
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SCAN  = 2'd1;
    localparam logic [1:0] ST_SHIFT = 2'd2;

    logic [1:0]              state_reg, state_next;
    logic [CNT_W-1:0]        count_reg, count_next;
    logic [IDX_W-1:0]        ptr_reg, ptr_next;
    logic                    iss_reg, iss_next;
    logic                    cmp_vld_reg, cmp_vld_next;
    logic [IDX_W-1:0]        cmp_idx_reg, cmp_idx_next;
    logic signed [DATA_W-1:0] best_reg, best_next;
    logic [IDX_W-1:0]        best_idx_reg, best_idx_next;
    logic                    done_reg, done_next;
    logic [1:0]              status_reg, status_next;
    logic signed [DATA_W-1:0] removed_reg, removed_next;

    logic                    we;
    logic [IDX_W-1:0]        wr_addr;
    logic [DATA_W-1:0]       wr_data;
    logic [DATA_W-1:0]       rd_data;

    logic [IDX_W-1:0]        last_idx;
    logic                    take;
    logic signed [DATA_W-1:0] cand_val;
    logic [IDX_W-1:0]        cand_idx;
    logic [CNT_W+COUNT_OUT_W-1:0] count_ext;

    mpq_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk     (clk),
        .we      (we),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (ptr_reg),
        .rd_data (rd_data)
    );

    assign last_idx = IDX_W'(count_reg - CNT_W'(1));

    // shared comparator: strict less keeps the oldest of equal minima
    assign take     = (cmp_idx_reg == '0) || ($signed(rd_data) < best_reg);
    assign cand_val = take ? $signed(rd_data) : best_reg;
    assign cand_idx = take ? cmp_idx_reg : best_idx_reg;

    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        ptr_next      = ptr_reg;
        iss_next      = iss_reg;
        cmp_vld_next  = 1'b0;
        cmp_idx_next  = cmp_idx_reg;
        best_next     = best_reg;
        best_idx_next = best_idx_reg;
        done_next     = 1'b0;
        status_next   = status_reg;
        removed_next  = removed_reg;
        we            = 1'b0;
        wr_addr       = IDX_W'(count_reg);
        wr_data       = value;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    removed_next = '0;
                    status_next  = STATUS_OK;
                    if (opcode == OP_INSERT)
                    begin
                        done_next = 1'b1;
                        if (count_reg == CNT_W'(DEPTH))
                        begin
                            status_next = STATUS_FULL;
                        end
                        else
                        begin
                            we         = 1'b1;
                            count_next = count_reg + CNT_W'(1);
                        end
                    end
                    else if (count_reg == '0)
                    begin
                        done_next   = 1'b1;
                        status_next = STATUS_EMPTY;
                    end
                    else
                    begin
                        state_next = ST_SCAN;
                        ptr_next   = '0;
                        iss_next   = 1'b1;
                    end
                end
            end

            ST_SCAN:
            begin
                if (iss_reg)
                begin
                    cmp_vld_next = 1'b1;
                    cmp_idx_next = ptr_reg;
                    if (ptr_reg == last_idx)
                    begin
                        iss_next = 1'b0;
                    end
                    else
                    begin
                        ptr_next = ptr_reg + IDX_W'(1);
                    end
                end
                if (cmp_vld_reg)
                begin
                    best_next     = cand_val;
                    best_idx_next = cand_idx;
                    if (cmp_idx_reg == last_idx)
                    begin
                        removed_next = cand_val;
                        if (cand_idx == last_idx)
                        begin
                            // minimum is the newest entry: nothing to close up
                            state_next = ST_IDLE;
                            count_next = count_reg - CNT_W'(1);
                            done_next  = 1'b1;
                        end
                        else
                        begin
                            state_next = ST_SHIFT;
                            ptr_next   = cand_idx + IDX_W'(1);
                            iss_next   = 1'b1;
                        end
                    end
                end
            end

            ST_SHIFT:
            begin
                if (iss_reg)
                begin
                    cmp_vld_next = 1'b1;
                    cmp_idx_next = ptr_reg;
                    if (ptr_reg == last_idx)
                    begin
                        iss_next = 1'b0;
                    end
                    else
                    begin
                        ptr_next = ptr_reg + IDX_W'(1);
                    end
                end
                if (cmp_vld_reg)
                begin
                    // entry read last cycle moves down one slot
                    we      = 1'b1;
                    wr_addr = cmp_idx_reg - IDX_W'(1);
                    wr_data = rd_data;
                    if (cmp_idx_reg == last_idx)
                    begin
                        state_next = ST_IDLE;
                        count_next = count_reg - CNT_W'(1);
                        done_next  = 1'b1;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            iss_reg     <= 1'b0;
            cmp_vld_reg <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            iss_reg     <= iss_next;
            cmp_vld_reg <= cmp_vld_next;
            done_reg    <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ptr_reg      <= ptr_next;
        cmp_idx_reg  <= cmp_idx_next;
        best_reg     <= best_next;
        best_idx_reg <= best_idx_next;
        status_reg   <= status_next;
        removed_reg  <= removed_next;
    end

    assign count_ext     = (CNT_W + COUNT_OUT_W)'(count_reg);
    assign busy          = (state_reg != ST_IDLE);
    assign done          = done_reg;
    assign status        = status_reg;
    assign removed_value = removed_reg;
    assign entry_count   = count_ext[COUNT_OUT_W-1:0];
    assign is_empty      = (count_reg == '0);

endmodule
